### hw/rtl/rec_aw_pkg.sv
// Shared types and constants for the record anti-replay window.
`timescale 1ns / 1ps
package rec_aw_pkg;

  localparam int unsigned WINDOW_SIZE = 64;
  localparam int unsigned WIN_IDX_W   = $clog2(WINDOW_SIZE);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] MAGIC_TKSR   = 32'h544B_5352;
  localparam logic [7:0]  WIRE_VERSION = 8'd1;
  localparam logic [15:0] HEADER_BYTES = 16'd32;
  localparam logic [15:0] TAG_BYTES    = 16'd16;

  localparam int unsigned IN_DATA_W  = 248;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_ADDR_W = 2;

  typedef enum logic [2:0] {
    V_OK        = 3'd0,
    V_NOT_READY = 3'd1,
    V_MALFORMED = 3'd2,
    V_DIRECTION = 3'd3,
    V_REPLAY    = 3'd4,
    V_AUTH      = 3'd5
  } verdict_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EPOCH = 2'd0,
    REG_DIR   = 2'd1,
    REG_READY = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] epoch;
    logic [7:0]  direction;
    logic        ready;
  } cfg_t;

  typedef struct packed {
    verdict_e    pre;
    logic [63:0] seq;
    logic [15:0] plen;
    logic        tag;
  } entry_t;

endpackage

### hw/rtl/rec_aw_front.sv
// Front end: accept record headers, run the stateless checks, queue the item.
`timescale 1ns / 1ps
module rec_aw_front (
  input  rec_aw_pkg::cfg_t   cfg_i,
  input  logic [rec_aw_pkg::IN_DATA_W-1:0] s_axis_tdata, // magic, version, direction,
                                                         // hdr len, epoch, seq, plen,
                                                         // total, room, zero pad
  input  logic               s_axis_tuser,  // tag_ok
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic               full_i,
  output logic               push_o,
  output rec_aw_pkg::entry_t entry_o
);
  import rec_aw_pkg::*;

  logic [31:0] magic;
  logic [7:0]  version;
  logic [7:0]  direction;
  logic [15:0] hdr_len;
  logic [63:0] epoch;
  logic [63:0] seq;
  logic [15:0] plen;
  logic [16:0] total;
  logic [15:0] room;
  logic [16:0] exp_total;
  logic        bad_struct;
  logic        bad_body;
  logic        unused_pad;

  assign magic      = s_axis_tdata[31:0];
  assign version    = s_axis_tdata[39:32];
  assign direction  = s_axis_tdata[47:40];
  assign hdr_len    = s_axis_tdata[63:48];
  assign epoch      = s_axis_tdata[127:64];
  assign seq        = s_axis_tdata[191:128];
  assign plen       = s_axis_tdata[207:192];
  assign total      = s_axis_tdata[224:208];
  assign room       = s_axis_tdata[240:225];
  assign unused_pad = ^s_axis_tdata[IN_DATA_W-1:241];

  assign exp_total = {1'b0, HEADER_BYTES} + {1'b0, TAG_BYTES} + {1'b0, plen};

  assign bad_struct = (total < ({1'b0, HEADER_BYTES} + {1'b0, TAG_BYTES})) ||
                      (magic != MAGIC_TKSR) || (version != WIRE_VERSION) ||
                      (hdr_len != HEADER_BYTES) || (epoch != cfg_i.epoch);
  assign bad_body   = (seq == 64'd0) || (plen == 16'd0) || (plen > room) ||
                      (total != exp_total);

  always_comb begin
    entry_o.seq  = seq;
    entry_o.plen = plen;
    entry_o.tag  = s_axis_tuser;
    if (!cfg_i.ready) begin
      entry_o.pre = V_NOT_READY;
    end else if (bad_struct) begin
      entry_o.pre = V_MALFORMED;
    end else if (direction != cfg_i.direction) begin
      entry_o.pre = V_DIRECTION;
    end else if (bad_body) begin
      entry_o.pre = V_MALFORMED;
    end else begin
      entry_o.pre = V_OK;
    end
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i && (unused_pad || !unused_pad);

endmodule

### hw/rtl/rec_aw_fifo.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module rec_aw_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rec_aw_pkg::entry_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rec_aw_pkg::entry_t data_o
);
  import rec_aw_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/rec_aw_back.sv
// Back end: replay window check and update, result register.
`timescale 1ns / 1ps
module rec_aw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               valid_i,
  input  rec_aw_pkg::entry_t entry_i,
  output logic               pop_o,
  output logic [rec_aw_pkg::OUT_DATA_W-1:0] m_axis_tdata, // verdict, accepted_length,
                                                          // zero pad
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready
);
  import rec_aw_pkg::*;

  logic [63:0]            hs_q, hs_d;
  logic [WINDOW_SIZE-1:0] mask_q, mask_d;
  logic                   out_valid_q, out_valid_d;
  verdict_e               verdict_q, verdict_d;
  logic [15:0]            len_q, len_d;
  logic                   ahead;
  logic [63:0]            dist_dn;
  logic [63:0]            dist_up;
  logic                   dn_far;
  logic                   up_far;
  logic                   replay;
  verdict_e               verdict_c;

  assign ahead   = entry_i.seq > hs_q;
  assign dist_dn = hs_q - entry_i.seq;
  assign dist_up = entry_i.seq - hs_q;
  assign dn_far  = dist_dn >= 64'(WINDOW_SIZE);
  assign up_far  = dist_up >= 64'(WINDOW_SIZE);
  assign replay  = !ahead && (dn_far || mask_q[dist_dn[WIN_IDX_W-1:0]]);

  always_comb begin
    if (entry_i.pre != V_OK) begin
      verdict_c = entry_i.pre;
    end else if (replay) begin
      verdict_c = V_REPLAY;
    end else if (!entry_i.tag) begin
      verdict_c = V_AUTH;
    end else begin
      verdict_c = V_OK;
    end
  end

  assign pop_o = valid_i && (!out_valid_q || m_axis_tready);

  always_comb begin
    hs_d        = hs_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    verdict_d   = verdict_q;
    len_d       = len_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      verdict_d   = verdict_c;
      len_d       = (verdict_c == V_OK) ? entry_i.plen : 16'd0;
      if (verdict_c == V_OK) begin
        if (ahead) begin
          hs_d = entry_i.seq;
          if (up_far) begin
            mask_d = WINDOW_SIZE'(1);
          end else begin
            mask_d = (mask_q << dist_up[WIN_IDX_W-1:0]) | WINDOW_SIZE'(1);
          end
        end else begin
          mask_d = mask_q | (WINDOW_SIZE'(1) << dist_dn[WIN_IDX_W-1:0]);
        end
      end
    end
    if (clear_i) begin
      hs_d   = '0;
      mask_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q        <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hs_q        <= hs_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    len_q     <= len_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 19){1'b0}}, len_q, verdict_q};

  a_len_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (verdict_q != V_OK)) |-> (len_q == 16'd0))
    else $error("accepted length nonzero on a rejected item");

  a_top_bit_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hs_q != 64'd0) |-> mask_q[0])
    else $error("highest accepted number not marked in window");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hs_q == 64'd0) |-> (mask_q == '0))
    else $error("window bits set with no accepted number");

  a_highest_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (verdict_c == V_OK) && !clear_i) |=> (hs_q >= $past(entry_i.seq)))
    else $error("highest number below an accepted number");

  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (verdict_q <= V_AUTH))
    else $error("verdict code out of range");

endmodule

### hw/rtl/record_antireplay_window.sv
// Top level of the record anti-replay window checker.
// A header accepted at the input is written into the queue; the back end pops it and registers its verdict.
// Throughput: one item per cycle while m_axis_tready stays high; the window compare, shift and update in the back
//   end are computed combinationally from the registered window state, so items follow back to back.
// Reset clears the configuration registers, the window state and the queue;
// writing the epoch register clears the window at once.
`timescale 1ns / 1ps
module record_antireplay_window (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rec_aw_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [63:0]                         cfg_wdata_i,
  input  logic [rec_aw_pkg::IN_DATA_W-1:0]    s_axis_tdata, // magic, version, direction,
                                                            // hdr len, epoch, seq, plen,
                                                            // total, room, zero pad
  input  logic                                s_axis_tuser, // tag_ok
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  output logic [rec_aw_pkg::OUT_DATA_W-1:0]   m_axis_tdata, // verdict, accepted_length,
                                                            // zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);
  import rec_aw_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   clear;
  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t front_entry;
  entry_t q_entry;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    clear = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_EPOCH: begin
          cfg_d.epoch = cfg_wdata_i;
          clear       = 1'b1;
        end
        REG_DIR:   cfg_d.direction = cfg_wdata_i[7:0];
        REG_READY: cfg_d.ready     = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rec_aw_front u_front (
    .cfg_i         (cfg_q),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  rec_aw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  rec_aw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (clear),
    .valid_i       (q_valid),
    .entry_i       (q_entry),
    .pop_o         (pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule
